// ----- sv/fil_pkg.sv -----
package fil_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int VALUE_W    = 32;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int COUNT_W    = 5;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic                      action;
        logic signed [VALUE_W-1:0] item_value;
    } in_t;

    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   count_after;
        logic                 is_empty;
    } out_t;

    typedef struct packed {
        logic insert_en;
        logic extract_en;
    } cell_ctrl_t;

endpackage

// ----- sv/fil_cell.sv -----
module fil_cell (
    input  logic                                aclk,
    input  fil_pkg::cell_ctrl_t                 ctrl,
    input  logic                                occupied,
    input  logic signed [fil_pkg::VALUE_W-1:0]  item_value,
    input  logic signed [fil_pkg::VALUE_W-1:0]  prev_value,
    input  logic signed [fil_pkg::VALUE_W-1:0]  next_value,
    input  logic                                hit_in,
    output logic signed [fil_pkg::VALUE_W-1:0]  value,
    output logic                                hit_out
);

    logic signed [fil_pkg::VALUE_W-1:0] value_reg;
    logic signed [fil_pkg::VALUE_W-1:0] value_next;
    logic                               match;

    assign match   = occupied && (value_reg == item_value);
    assign hit_out = hit_in || match;
    assign value   = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.insert_en) begin
            value_next = prev_value;
        end else if (ctrl.extract_en && hit_out) begin
            value_next = next_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// ----- sv/front_insert_list_with_extract.sv -----
// Channel | Ports                     | Carries
// input   | s_valid s_ready s_data    | action, item_value
// result  | m_valid m_ready m_data    | status, count_after, is_empty
//
// One transaction per cycle while s_ready is high: each item updates the cell
// chain at the edge that accepts it, where its result is also registered; the
// result is valid from the next cycle on.
// The match search runs as a priority chain through the cells.
// Reset clears the count and the result valid; cell contents are not reset.
// s_ready drops only while a result is held and m_ready is low.
module front_insert_list_with_extract (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  fil_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output fil_pkg::out_t  m_data
);

    localparam int N = fil_pkg::LIST_DEPTH;
    localparam int W = fil_pkg::VALUE_W;
    localparam int C = fil_pkg::CNT_W;

    logic [C-1:0]         count_reg;
    logic [C-1:0]         count_next;
    logic                 m_valid_reg;
    fil_pkg::out_t        m_data_reg;
    fil_pkg::out_t        m_data_next;

    logic                 accept;
    logic                 full;
    logic                 found;
    fil_pkg::cell_ctrl_t  ctrl;

    logic signed [W-1:0]  cell_value [N];
    logic                 hit        [N+1];
    logic [C+fil_pkg::COUNT_W-1:0] count_wide;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == C'(N));
    assign found   = hit[N];

    assign ctrl.insert_en  = accept && (s_data.action == fil_pkg::ACT_INSERT) && !full;
    assign ctrl.extract_en = accept && (s_data.action == fil_pkg::ACT_EXTRACT);

    assign hit[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_cell
            logic signed [W-1:0] prev_v;
            logic signed [W-1:0] next_v;
            if (i == 0) begin : g_first
                assign prev_v = s_data.item_value;
            end else begin : g_mid
                assign prev_v = cell_value[i-1];
            end
            if (i == N - 1) begin : g_last
                assign next_v = cell_value[i];
            end else begin : g_inner
                assign next_v = cell_value[i+1];
            end
            fil_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occupied   (C'(i) < count_reg),
                .item_value (s_data.item_value),
                .prev_value (prev_v),
                .next_value (next_v),
                .hit_in     (hit[i]),
                .value      (cell_value[i]),
                .hit_out    (hit[i+1])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        m_data_next.status = fil_pkg::ST_DONE;
        if (s_data.action == fil_pkg::ACT_INSERT) begin
            if (full) begin
                m_data_next.status = fil_pkg::ST_FULL;
            end else begin
                count_next = count_reg + C'(1);
            end
        end else begin
            if (found) begin
                count_next = count_reg - C'(1);
            end else begin
                m_data_next.status = fil_pkg::ST_NOT_FOUND;
            end
        end
        count_wide               = {{fil_pkg::COUNT_W{1'b0}}, count_next};
        m_data_next.count_after  = count_wide[fil_pkg::COUNT_W-1:0];
        m_data_next.is_empty     = (count_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- sv/fil_checker.sv -----
module fil_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  fil_pkg::in_t   s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  fil_pkg::out_t  m_data
);

    localparam logic [fil_pkg::COUNT_W-1:0] FULL_COUNT =
        fil_pkg::COUNT_W'(fil_pkg::LIST_DEPTH);

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted transaction produced no result");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (fil_pkg::LIST_DEPTH > 31) ||
                    (m_data.is_empty == (m_data.count_after == '0)))
        else $error("empty flag disagrees with count");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == fil_pkg::ST_FULL)
            |-> m_data.count_after == FULL_COUNT && !m_data.is_empty)
        else $error("full status with wrong count");

    a_insert_status: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.action == fil_pkg::ACT_INSERT)
            |=> m_data.status != fil_pkg::ST_NOT_FOUND)
        else $error("insert reported value not found");

endmodule

bind front_insert_list_with_extract fil_checker u_fil_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/tb_front_insert_list_with_extract.sv -----
module tb_front_insert_list_with_extract;

    localparam int   HOLD_LEN    = 60;
    localparam int   STALL_LIMIT = 2000;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    fil_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    fil_pkg::out_t m_data;

    logic signed [fil_pkg::VALUE_W-1:0] list_model[$];
    fil_pkg::out_t                      pending_results[$];
    int                                 error_count;
    int                                 stall_cycles;
    int                                 hold_cycles;
    logic                               idle_on;
    logic                               hold_output;
    logic                               insert_heavy;

    front_insert_list_with_extract dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Expected list behavior: front insert, frontmost-match extract.
    function automatic fil_pkg::out_t update_list_model(fil_pkg::in_t item);
        fil_pkg::out_t res;
        int            hit;
        res.status = fil_pkg::ST_DONE;
        hit = -1;
        if (item.action == fil_pkg::ACT_INSERT) begin
            if (list_model.size() >= fil_pkg::LIST_DEPTH) begin
                res.status = fil_pkg::ST_FULL;
            end else begin
                list_model.push_front(item.item_value);
            end
        end else begin
            foreach (list_model[i]) begin
                if (hit < 0 && list_model[i] == item.item_value) begin
                    hit = i;
                end
            end
            if (hit < 0) begin
                res.status = fil_pkg::ST_NOT_FOUND;
            end else begin
                list_model.delete(hit);
            end
        end
        res.count_after = fil_pkg::COUNT_W'(list_model.size());
        res.is_empty    = (list_model.size() == 0);
        return res;
    endfunction

    function automatic fil_pkg::in_t random_item();
        fil_pkg::in_t item;
        int           pick;
        logic signed [fil_pkg::VALUE_W-1:0] pool_value;
        pick = $urandom_range(0, 9);
        if (insert_heavy) begin
            item.action = ($urandom_range(0, 3) != 0) ? fil_pkg::ACT_INSERT
                                                       : fil_pkg::ACT_EXTRACT;
        end else begin
            item.action = ($urandom_range(0, 3) != 0) ? fil_pkg::ACT_EXTRACT
                                                       : fil_pkg::ACT_INSERT;
        end
        pool_value = $urandom_range(0, 7);
        pool_value = pool_value - 3;
        if (item.action == fil_pkg::ACT_EXTRACT && list_model.size() != 0
                && pick < 6) begin
            item.item_value = list_model[$urandom_range(0, list_model.size() - 1)];
        end else if (pick < 7) begin
            item.item_value = pool_value;
        end else begin
            item.item_value = $urandom;
        end
        return item;
    endfunction

    task automatic offer_item(input fil_pkg::in_t item);
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(update_list_model(item));
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    task automatic offer(input logic act,
                         input logic signed [fil_pkg::VALUE_W-1:0] value);
        fil_pkg::in_t item;
        item.action     = act;
        item.item_value = value;
        offer_item(item);
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_edge_values();
        offer(fil_pkg::ACT_EXTRACT, 32'sd0);
        offer(fil_pkg::ACT_INSERT, 32'sh8000_0000);
        offer(fil_pkg::ACT_INSERT, 32'sh7fff_ffff);
        offer(fil_pkg::ACT_INSERT, 32'sd0);
        offer(fil_pkg::ACT_INSERT, -32'sd1);
        offer(fil_pkg::ACT_EXTRACT, 32'sd1);
        offer(fil_pkg::ACT_EXTRACT, 32'sh7fff_ffff);
        offer(fil_pkg::ACT_INSERT, 32'sd5);
        offer(fil_pkg::ACT_INSERT, 32'sd5);
        offer(fil_pkg::ACT_EXTRACT, 32'sd5);
        offer(fil_pkg::ACT_EXTRACT, 32'sh8000_0000);
        drain();
    endtask

    task automatic test_full_list();
        int n;
        n = 0;
        while (list_model.size() < fil_pkg::LIST_DEPTH) begin
            offer(fil_pkg::ACT_INSERT,
                  (n % 2 == 0) ? 32'sh5555_aaaa + n : 32'shaaaa_5555 - n);
            n++;
        end
        offer(fil_pkg::ACT_INSERT, 32'sd77);
        offer(fil_pkg::ACT_EXTRACT, 32'sd5);
        offer(fil_pkg::ACT_INSERT, 32'sd77);
        drain();
    endtask

    task automatic test_random_traffic(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 32 == 0) begin
                insert_heavy = ~insert_heavy;
            end
            offer_item(random_item());
        end
        drain();
    endtask

    // Receiver holds off while the sender keeps offering, so input stalls.
    task automatic test_output_backpressure();
        hold_output = 1'b1;
        for (int i = 0; i < 40; i++) begin
            offer_item(random_item());
        end
        drain();
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_output) begin
                m_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < HOLD_LEN; hold_cycles++) begin
                    @(posedge aclk);
                end
                hold_output = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_result
        fil_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, got %p", $time, m_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status != want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, m_data.status);
                    error_count++;
                end
                if (m_data.count_after != want.count_after) begin
                    $display("%0t: count_after expected %0d got %0d",
                             $time, want.count_after, m_data.count_after);
                    error_count++;
                end
                if (m_data.is_empty != want.is_empty) begin
                    $display("%0t: is_empty expected %0b got %0b",
                             $time, want.is_empty, m_data.is_empty);
                    error_count++;
                end
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        error_count  = 0;
        idle_on      = 1'b1;
        hold_output  = 1'b0;
        insert_heavy = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_edge_values();
        test_full_list();
        test_output_backpressure();
        test_random_traffic(280);
        idle_on = 1'b0;
        test_random_traffic(60);

        repeat (4) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
